### design/teq_pkg.sv
`default_nettype none
package teq_pkg;

  localparam int unsigned DepthDefault = 16;

  localparam logic [63:0] WrapWindow = 64'h0800_0000_0000_0000;

  localparam logic [1:0] ReqAdd    = 2'd0;
  localparam logic [1:0] ReqDelete = 2'd1;
  localparam logic [1:0] ReqCheck  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  event_id;
    logic [63:0] delay_cycles;
    logic [63:0] now_cycle;
  } req_t;

  typedef struct packed {
    logic       fired;
    logic [7:0] fired_id;
    logic       add_dropped;
    logic [4:0] pending_count;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  id;
    logic [63:0] due;
  } slot_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_REMOVE,
    CELL_INSERT
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e  mode;
    logic [7:0]  key_id;
    logic [63:0] key_due;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### design/teq_cell.sv
`default_nettype none
module teq_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  teq_pkg::cell_ctrl_t ctrl_i,
  input  teq_pkg::slot_t      left_i,
  input  teq_pkg::slot_t      right_i,
  input  wire                 chain_i,
  output logic                chain_o,
  output teq_pkg::slot_t      slot_o
);

  logic        valid_q, valid_d;
  logic [7:0]  id_q, id_d;
  logic [63:0] due_q, due_d;
  logic [63:0] diff;
  logic        hit;
  logic        cond;

  assign diff = due_q - ctrl_i.key_due;
  assign hit  = valid_q && (id_q == ctrl_i.key_id);
  assign cond = !valid_q || (diff < teq_pkg::WrapWindow);

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    due_d   = due_q;
    chain_o = chain_i;
    case (ctrl_i.mode)
      teq_pkg::CELL_REMOVE: begin
        chain_o = chain_i | hit;
        if (chain_i || hit) begin
          valid_d = right_i.valid;
          id_d    = right_i.id;
          due_d   = right_i.due;
        end
      end
      teq_pkg::CELL_INSERT: begin
        chain_o = chain_i | cond;
        if (chain_i) begin
          valid_d = left_i.valid;
          id_d    = left_i.id;
          due_d   = left_i.due;
        end else if (cond) begin
          valid_d = 1'b1;
          id_d    = ctrl_i.key_id;
          due_d   = ctrl_i.key_due;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    due_q <= due_d;
  end

  assign slot_o = '{valid: valid_q, id: id_q, due: due_q};

endmodule
`default_nettype wire

### design/timed_event_queue_top.sv
`default_nettype none
// Channel   Direction  Handshake           Payload
// request   in         start, busy         req_i  (teq_pkg::req_t)
// result    out        done_o strobe       rsp_o  (teq_pkg::rsp_t)
//
// done_o follows the transfer through S_FIRST for delete, check and unused
// requests, and through S_FIRST then S_INSERT for add (a cancel pass, then an
// insert pass). busy is high from the transfer until the result strobe, so a
// new transfer can land in the strobe cycle, but not before the last result.
// After reset the queue is empty; the receiver cannot stall, each result
// is on rsp_o for the single cycle that done_o is high.
module timed_event_queue_top #(
  parameter int unsigned DEPTH = teq_pkg::DepthDefault
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start,
  output logic          busy,
  input  teq_pkg::req_t req_i,
  output logic          done_o,
  output teq_pkg::rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_INSERT
  } state_e;

  state_e              state_q;
  teq_pkg::req_t       req_q;
  logic [63:0]         due_q;
  logic [CW-1:0]       count_q, count_d;
  logic                done_q;
  teq_pkg::rsp_t       rsp_q;

  teq_pkg::cell_ctrl_t ctrl;
  logic                seed;
  logic                fire;
  logic                full;
  logic [63:0]         head_diff;
  logic [CW+4:0]       count_ext;

  teq_pkg::slot_t      slots [DEPTH];
  logic [DEPTH:0]      chain;

  assign chain[0] = seed;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    teq_pkg::slot_t left_s, right_s;
    if (i == 0) begin : g_first
      assign left_s = '0;
    end else begin : g_mid
      assign left_s = slots[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_s = '0;
    end else begin : g_rest
      assign right_s = slots[i+1];
    end
    teq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left_s),
      .right_i (right_s),
      .chain_i (chain[i]),
      .chain_o (chain[i+1]),
      .slot_o  (slots[i])
    );
  end

  assign head_diff = slots[0].due - req_q.now_cycle;
  assign full      = (count_q == CW'(DEPTH));

  always_comb begin
    ctrl.mode    = teq_pkg::CELL_HOLD;
    ctrl.key_id  = req_q.event_id;
    ctrl.key_due = due_q;
    seed         = 1'b0;
    fire         = 1'b0;
    count_d      = count_q;
    case (state_q)
      S_FIRST: begin
        case (req_q.req_type)
          teq_pkg::ReqAdd, teq_pkg::ReqDelete: begin
            ctrl.mode = teq_pkg::CELL_REMOVE;
            if (chain[DEPTH]) begin
              count_d = count_q - CW'(1);
            end
          end
          teq_pkg::ReqCheck: begin
            fire = slots[0].valid &&
                   (slots[0].due == req_q.now_cycle || head_diff >= teq_pkg::WrapWindow);
            if (fire) begin
              ctrl.mode = teq_pkg::CELL_REMOVE;
              seed      = 1'b1;
              count_d   = count_q - CW'(1);
            end
          end
          default: ;
        endcase
      end
      S_INSERT: begin
        if (!full) begin
          ctrl.mode = teq_pkg::CELL_INSERT;
          count_d   = count_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign count_ext = {5'b0, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
      req_q   <= '0;
      due_q   <= '0;
    end else begin
      count_q <= count_d;
      case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (start) begin
            req_q   <= req_i;
            due_q   <= req_i.now_cycle + req_i.delay_cycles;
            state_q <= S_FIRST;
          end
        end
        S_FIRST: begin
          if (req_q.req_type == teq_pkg::ReqAdd) begin
            state_q <= S_INSERT;
            done_q  <= 1'b0;
          end else begin
            state_q             <= S_IDLE;
            done_q              <= 1'b1;
            rsp_q.fired         <= fire;
            rsp_q.fired_id      <= fire ? slots[0].id : 8'd0;
            rsp_q.add_dropped   <= 1'b0;
            rsp_q.pending_count <= count_ext[4:0];
          end
        end
        S_INSERT: begin
          state_q             <= S_IDLE;
          done_q              <= 1'b1;
          rsp_q.fired         <= 1'b0;
          rsp_q.fired_id      <= 8'd0;
          rsp_q.add_dropped   <= full;
          rsp_q.pending_count <= count_ext[4:0];
        end
        default: begin
          state_q <= S_IDLE;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
`default_nettype wire

### tb/timed_event_queue_checker.sv
module timed_event_queue_checker #(
  parameter int unsigned DEPTH = teq_pkg::DepthDefault
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start_i,
  input  wire           busy_i,
  input  teq_pkg::req_t req_i,
  input  wire           done_i,
  input  teq_pkg::rsp_t rsp_i,
  output int            fail_count_o,
  output int            outstanding_o,
  output int            fired_total_o,
  output int            dropped_total_o
);

  typedef struct packed {
    logic [7:0]  id;
    logic [63:0] due;
  } timer_t;

  // pending timers, head first
  timer_t        timers[$];
  teq_pkg::rsp_t expected_rsp[$];

  function automatic void cancel_timer(logic [7:0] id);
    for (int i = 0; i < timers.size(); i++) begin
      if (timers[i].id == id) begin
        timers.delete(i);
        return;
      end
    end
  endfunction

  function automatic teq_pkg::rsp_t serve_request(teq_pkg::req_t r);
    teq_pkg::rsp_t rsp;
    logic [63:0]   due;
    int            pos;
    rsp = '0;
    case (r.req_type)
      teq_pkg::ReqAdd: begin
        due = r.now_cycle + r.delay_cycles;
        cancel_timer(r.event_id);
        if (timers.size() >= DEPTH) begin
          rsp.add_dropped = 1'b1;
        end else begin
          pos = 0;
          while (pos < timers.size() &&
                 (timers[pos].due - due) >= teq_pkg::WrapWindow) begin
            pos++;
          end
          timers.insert(pos, '{id: r.event_id, due: due});
        end
      end
      teq_pkg::ReqDelete: begin
        cancel_timer(r.event_id);
      end
      teq_pkg::ReqCheck: begin
        if (timers.size() > 0) begin
          if (timers[0].due == r.now_cycle ||
              (timers[0].due - r.now_cycle) >= teq_pkg::WrapWindow) begin
            rsp.fired    = 1'b1;
            rsp.fired_id = timers[0].id;
            timers.delete(0);
          end
        end
      end
      default: ;
    endcase
    rsp.pending_count = 5'(timers.size());
    return rsp;
  endfunction

  function automatic void note_failure(string msg);
    if (fail_count_o < 10) begin
      $display("%s", msg);
    end
    fail_count_o++;
  endfunction

  always @(posedge clk_i) begin
    teq_pkg::rsp_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_rsp.size() == 0) begin
          note_failure($sformatf(
            "ERROR result with none pending: fired=%0b id=%0d drop=%0b cnt=%0d",
            rsp_i.fired, rsp_i.fired_id, rsp_i.add_dropped, rsp_i.pending_count));
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_i.fired !== want.fired || rsp_i.fired_id !== want.fired_id ||
              rsp_i.add_dropped !== want.add_dropped ||
              rsp_i.pending_count !== want.pending_count) begin
            note_failure($sformatf({"ERROR result: exp fired=%0b id=%0d drop=%0b cnt=%0d,",
                                    " got fired=%0b id=%0d drop=%0b cnt=%0d"},
              want.fired, want.fired_id, want.add_dropped, want.pending_count,
              rsp_i.fired, rsp_i.fired_id, rsp_i.add_dropped, rsp_i.pending_count));
          end
        end
      end
      if (start_i && !busy_i) begin
        want = serve_request(req_i);
        expected_rsp.push_back(want);
        if (want.fired) fired_total_o++;
        if (want.add_dropped) dropped_total_o++;
      end
    end
    outstanding_o = expected_rsp.size();
  end

endmodule

### tb/timed_event_queue_top_tb.sv
module timed_event_queue_top_tb;

  localparam logic [1:0]  ReqUnused      = 2'd3;
  localparam int unsigned RandomRequests = 820;
  localparam int unsigned QuietTail      = 100;
  localparam int unsigned StallLimit     = 1000;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  logic          done_o;
  teq_pkg::req_t req_i;
  teq_pkg::rsp_t rsp_o;

  int          fail_count;
  int          outstanding;
  int          fired_total;
  int          dropped_total;
  int          idle_cycles;
  int          sent_by_type[4];
  int          add_share;
  logic [63:0] now_cursor;

  timed_event_queue_top u_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .done_o,
    .rsp_o
  );

  timed_event_queue_checker u_checker (
    .clk_i,
    .rst_ni,
    .start_i        (start),
    .busy_i         (busy),
    .req_i,
    .done_i         (done_o),
    .rsp_i          (rsp_o),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .fired_total_o  (fired_total),
    .dropped_total_o(dropped_total)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("timed_event_queue_top_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic teq_pkg::req_t make_req(logic [1:0] kind, logic [7:0] id,
                                             logic [63:0] dly, logic [63:0] now);
    teq_pkg::req_t r;
    r.req_type     = kind;
    r.event_id     = id;
    r.delay_cycles = dly;
    r.now_cycle    = now;
    return r;
  endfunction

  task automatic submit(teq_pkg::req_t r);
    req_i <= r;
    start <= 1'b1;
    sent_by_type[r.req_type]++;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    req_i <= {10'($urandom), rand64(), rand64()};
    repeat (n) @(negedge clk_i);
  endtask

  // mostly timer traffic on a running clock with a small id pool, some noise
  function automatic teq_pkg::req_t random_request();
    int          roll;
    logic [1:0]  kind;
    logic [7:0]  id;
    logic [63:0] dly;
    now_cursor += 64'($urandom_range(0, 6));
    if ($urandom_range(0, 99) == 0) now_cursor = rand64();
    if ($urandom_range(0, 99) < 5) begin
      return make_req(2'($urandom), 8'($urandom), rand64(), rand64());
    end
    id = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 23)) : 8'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < add_share) kind = teq_pkg::ReqAdd;
    else if (roll < add_share + 12) kind = teq_pkg::ReqDelete;
    else if (roll < 97) kind = teq_pkg::ReqCheck;
    else kind = ReqUnused;
    roll = $urandom_range(0, 9);
    if (roll < 8) dly = 64'($urandom_range(0, 40));
    else if (roll == 8) dly = teq_pkg::WrapWindow - 64'd2 + 64'($urandom_range(0, 3));
    else dly = rand64();
    return make_req(kind, id, dly, now_cursor);
  endfunction

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    add_share = 40;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty queue, absent id, unused request
    submit(make_req(teq_pkg::ReqCheck, 8'h00, '1, 64'd0));
    submit(make_req(teq_pkg::ReqDelete, 8'hFF, 64'd0, '1));
    submit(make_req(ReqUnused, 8'hA5, '1, '1));
    // due exactly now
    submit(make_req(teq_pkg::ReqAdd, 8'h00, 64'd0, 64'd0));
    submit(make_req(teq_pkg::ReqCheck, 8'h00, 64'd0, 64'd0));
    // due time wraps, head due one less than now
    submit(make_req(teq_pkg::ReqAdd, 8'hFF, '1, '1));
    submit(make_req(teq_pkg::ReqCheck, 8'h00, 64'd0, '1));
    // window edges of the due rule
    submit(make_req(teq_pkg::ReqAdd, 8'h07, teq_pkg::WrapWindow, 64'd0));
    submit(make_req(teq_pkg::ReqCheck, 8'h00, 64'd0, 64'd0));
    submit(make_req(teq_pkg::ReqAdd, 8'h07, teq_pkg::WrapWindow - 64'd1, 64'd0));
    submit(make_req(teq_pkg::ReqAdd, 8'h08, 64'd0, 64'd0));
    // fill with repeated due times; the last add hits a full queue
    for (int k = 0; k < 15; k++) begin
      submit(make_req(teq_pkg::ReqAdd, 8'(8'h80 + k), 64'((k % 5) * 16), 64'h1000));
    end
    // re-add of a held id while full, delete, check
    submit(make_req(teq_pkg::ReqAdd, 8'h08, 64'd300, 64'h1000));
    submit(make_req(teq_pkg::ReqDelete, 8'h07, 64'd0, 64'd0));
    submit(make_req(teq_pkg::ReqCheck, 8'h00, 64'd0, 64'h1000));

    now_cursor = 64'hFFFF_FFFF_FFFF_FC00 - 64'($urandom_range(0, 1000));
    for (int k = 0; k < RandomRequests; k++) begin
      if (k % 50 == 0) add_share = $urandom_range(25, 70);
      submit(random_request());
      if (k < RandomRequests - QuietTail && $urandom_range(0, 5) == 0) begin
        pause($urandom_range(1, 16));
      end
    end
    start <= 1'b0;

    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("requests: %0d add, %0d delete, %0d check, %0d unused",
             sent_by_type[teq_pkg::ReqAdd], sent_by_type[teq_pkg::ReqDelete],
             sent_by_type[teq_pkg::ReqCheck], sent_by_type[ReqUnused]);
    $display("events fired: %0d, adds refused on full queue: %0d, mismatches: %0d",
             fired_total, dropped_total, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("timed_event_queue_top_tb passed");
    end else begin
      $display("timed_event_queue_top_tb failed");
    end
    $finish;
  end

endmodule
